// ===== rtl/kfr_pkg.sv =====
// ============================================================================
// KISS frame receiver package
// Field widths, protocol byte codes, command and event codes, sequencer
// states and the memory control bundle shared by the receiver modules.
// ============================================================================
`timescale 1ns / 1ps

package kfr_pkg;

   localparam int BUF_DEPTH_DEFAULT = 512;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 9;
   localparam int LEN_W   = 9;
   localparam int EV_W    = 2;

   localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
   localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
   localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
   localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

   localparam logic [BYTE_W-1:0] CMD_NIBBLE_MASK = 8'h0F;
   localparam int                MIN_FRAME_LEN   = 16;
   localparam int                LAST_CHECKED    = 13;
   localparam logic [LEN_W-1:0]  LEN_MAX         = 9'h1FF;

   localparam int             CHK_W   = 4;
   localparam logic [CHK_W-1:0] CHK_LAST = 4'(LAST_CHECKED);
   localparam logic [CHK_W-1:0] CHK_END  = 4'(LAST_CHECKED + 1);

   localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EV_W-1:0] EV_ACCEPT  = 2'd1;
   localparam logic [EV_W-1:0] EV_DISCARD = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_RD_WAIT,
      ST_ESC,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic bank;
   } mem_ctl_type;

endpackage

// ===== rtl/kfr_frame_mem.sv =====
// ============================================================================
// KISS frame receiver frame memory
// Two byte-wide banks that share one address. Writes go to the selected
// bank; reads fetch both banks into registers and return the selected one in the next cycle.
// ============================================================================
`timescale 1ns / 1ps

module kfr_frame_mem #(
   parameter  int BUF_DEPTH = kfr_pkg::BUF_DEPTH_DEFAULT,
   localparam int AW        = $clog2(BUF_DEPTH)
) (
   input  logic                       clock,
   input  kfr_pkg::mem_ctl_type       ctl,
   input  logic [AW-1:0]              addr,
   input  logic [kfr_pkg::BYTE_W-1:0] wr_data,
   output logic [kfr_pkg::BYTE_W-1:0] rd_data
);
   import kfr_pkg::*;

   logic [BYTE_W-1:0] store_a_ff [BUF_DEPTH];
   logic [BYTE_W-1:0] store_b_ff [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_a_ff;
   logic [BYTE_W-1:0] rd_b_ff;
   logic              rd_bank_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && !ctl.bank) begin
         store_a_ff[addr] <= wr_data;
      end
      if (ctl.wr_en && ctl.bank) begin
         store_b_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff    <= store_a_ff[addr];
         rd_b_ff    <= store_b_ff[addr];
         rd_bank_ff <= ctl.bank;
      end
   end

   assign rd_data = rd_bank_ff ? rd_b_ff : rd_a_ff;

endmodule

// ===== rtl/kiss_frame_receiver_core.sv =====
// ============================================================================
// KISS frame receiver core
// One request at a time; the next is taken in the cycle after the
// response is loaded. The end marker check reads 14 stored bytes
// through the single memory read port. Reset clears the state, heads,
// bank select, hold flag and response valid; frame memory contents are
// not cleared.
// ============================================================================
`timescale 1ns / 1ps

module kiss_frame_receiver_core #(
   parameter  int BUF_DEPTH = kfr_pkg::BUF_DEPTH_DEFAULT,
   localparam int AW        = $clog2(BUF_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [kfr_pkg::CMD_W-1:0]   req_command,
   input  logic [kfr_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [kfr_pkg::INDEX_W-1:0] req_read_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_frame_ready,
   output logic [kfr_pkg::LEN_W-1:0]   rsp_frame_length,
   output logic [kfr_pkg::BYTE_W-1:0]  rsp_read_data,
   output logic [kfr_pkg::EV_W-1:0]    rsp_event_res
);
   import kfr_pkg::*;

   localparam int PW = (INDEX_W + 1 > AW + 1) ? INDEX_W + 1 : AW + 1;
   localparam int LW = (AW > LEN_W) ? AW : LEN_W;

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              bank_ff, bank_in;
   logic [AW-1:0]     main_head_ff, main_head_in;
   logic [AW-1:0]     spare_head_ff, spare_head_in;
   logic              held_ff, held_in;
   logic [CHK_W-1:0]  chk_cnt_ff, chk_cnt_in;
   logic              fail_ff, fail_in;
   logic [EV_W-1:0]   ev_ff, ev_in;
   logic [BYTE_W-1:0] data_ff, data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ready_ff, rsp_ready_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [EV_W-1:0]   rsp_ev_ff, rsp_ev_in;

   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [BYTE_W-1:0] mem_rd_data;

   logic              req_accept;
   logic              out_free;
   logic              bank_cur;
   logic [AW-1:0]     head_cur;
   logic [AW-1:0]     head_prev;
   logic [AW-1:0]     head_next;
   logic              esc_cand;
   logic              pos_wraps;
   logic              chk_bad;
   logic              chk_fail;
   logic [LW-1:0]     len_wide;
   logic [LEN_W-1:0]  len_sat;

   kfr_frame_mem #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign bank_cur  = held_ff ? !bank_ff : bank_ff;
   assign head_cur  = held_ff ? spare_head_ff : main_head_ff;
   assign head_prev = head_cur - 1'b1;
   assign head_next = (head_cur == AW'(BUF_DEPTH - 1)) ? '0 : head_cur + 1'b1;
   assign esc_cand  = (head_cur != '0) && ((byte_ff == TFEND) || (byte_ff == TFESC));
   assign pos_wraps = (pos_ff >= PW'(BUF_DEPTH));

   assign chk_bad  = (chk_cnt_ff == 4'd1) ? ((mem_rd_data & CMD_NIBBLE_MASK) != '0)
                                          : mem_rd_data[0];
   assign chk_fail = fail_ff || ((chk_cnt_ff != '0) && chk_bad);

   assign len_wide = LW'(main_head_ff) - 1'b1;
   assign len_sat  = (len_wide > LW'(LEN_MAX)) ? LEN_MAX : len_wide[LEN_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_READ) begin
               state_in = ST_REDUCE;
            end else if ((cmd_ff == CMD_BYTE) && (byte_ff == FEND)) begin
               if (!held_ff && (main_head_ff >= AW'(MIN_FRAME_LEN))) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DONE;
               end
            end else if ((cmd_ff == CMD_BYTE) && esc_cand) begin
               state_in = ST_ESC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REDUCE: begin
            if (!pos_wraps) begin
               state_in = ST_RD_WAIT;
            end
         end
         ST_RD_WAIT: state_in = ST_DONE;
         ST_ESC:     state_in = ST_DONE;
         ST_CHECK: begin
            if (chk_cnt_ff == CHK_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      bank_in       = bank_ff;
      main_head_in  = main_head_ff;
      spare_head_in = spare_head_ff;
      held_in       = held_ff;
      chk_cnt_in    = chk_cnt_ff;
      fail_in       = fail_ff;
      ev_in         = ev_ff;
      data_in       = data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ready_in  = rsp_ready_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_ev_in     = rsp_ev_ff;
      mem_ctl       = '0;
      mem_ctl.bank  = bank_cur;
      mem_addr      = head_cur;
      mem_wr_data   = byte_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in  = req_command;
               byte_in = req_rx_byte;
               pos_in  = PW'(req_read_index) + 1'b1;
               ev_in   = EV_NONE;
               data_in = '0;
            end
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_RELEASE) begin
               if (held_ff) begin
                  bank_in       = !bank_ff;
                  main_head_in  = spare_head_ff;
                  spare_head_in = '0;
                  held_in       = 1'b0;
               end
            end else if ((cmd_ff == CMD_BYTE) && (byte_ff == FEND)) begin
               if (held_ff) begin
                  spare_head_in = '0;
               end else if (main_head_ff == '0) begin
                  ev_in = EV_NONE;
               end else if (main_head_ff < AW'(MIN_FRAME_LEN)) begin
                  main_head_in = '0;
                  ev_in        = EV_DISCARD;
               end else begin
                  chk_cnt_in = '0;
                  fail_in    = 1'b0;
               end
            end else if (cmd_ff == CMD_BYTE) begin
               if (esc_cand) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_addr      = head_prev;
               end else begin
                  mem_ctl.wr_en = 1'b1;
                  if (held_ff) begin
                     spare_head_in = head_next;
                  end else begin
                     main_head_in = head_next;
                  end
               end
            end
         end
         ST_ESC: begin
            mem_ctl.wr_en = 1'b1;
            if (mem_rd_data == FESC) begin
               mem_addr    = head_prev;
               mem_wr_data = (byte_ff == TFEND) ? FEND : FESC;
            end else if (held_ff) begin
               spare_head_in = head_next;
            end else begin
               main_head_in = head_next;
            end
         end
         ST_REDUCE: begin
            mem_ctl.bank = bank_ff;
            mem_addr     = pos_ff[AW-1:0];
            if (pos_wraps) begin
               pos_in = pos_ff - PW'(BUF_DEPTH);
            end else begin
               mem_ctl.rd_en = 1'b1;
            end
         end
         ST_RD_WAIT: begin
            data_in = mem_rd_data;
         end
         ST_CHECK: begin
            mem_ctl.bank  = bank_ff;
            mem_ctl.rd_en = (chk_cnt_ff <= CHK_LAST);
            mem_addr      = AW'(chk_cnt_ff);
            chk_cnt_in    = chk_cnt_ff + 1'b1;
            fail_in       = chk_fail;
            if (chk_cnt_ff == CHK_END) begin
               if (chk_fail) begin
                  main_head_in = '0;
                  ev_in        = EV_DISCARD;
               end else begin
                  held_in       = 1'b1;
                  spare_head_in = '0;
                  ev_in         = EV_ACCEPT;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ready_in = held_ff;
               rsp_len_in   = (held_ff && (main_head_ff != '0)) ? len_sat : '0;
               rsp_data_in  = data_ff;
               rsp_ev_in    = ev_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         main_head_ff  <= '0;
         spare_head_ff <= '0;
         held_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         main_head_ff  <= main_head_in;
         spare_head_ff <= spare_head_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      byte_ff      <= byte_in;
      pos_ff       <= pos_in;
      chk_cnt_ff   <= chk_cnt_in;
      fail_ff      <= fail_in;
      ev_ff        <= ev_in;
      data_ff      <= data_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ev_ff    <= rsp_ev_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_ready  = rsp_ready_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_event_res    = rsp_ev_ff;

   a_spare_only_when_held: assert property (@(posedge clock) disable iff (reset)
      (spare_head_ff != '0) |-> held_ff)
      else $error("spare buffer holds bytes while no frame is held");

   a_check_preconditions: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (!held_ff && (main_head_ff >= AW'(MIN_FRAME_LEN))))
      else $error("frame check running on a held or short frame");

   a_accept_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_ACCEPT)) |-> rsp_frame_ready)
      else $error("accept event reported without a held frame");

   a_length_only_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ready) |-> (rsp_frame_length == '0))
      else $error("frame length reported while no frame is held");

endmodule

// ===== tb/tb_kiss_frame_receiver_core.sv =====
// ============================================================================
// KISS frame receiver core testbench
// Sends serial bytes, reads and releases through the request channel and
// checks every response against a local model of the frame stores, the
// un-escaping and the end-of-frame acceptance rules. Both channels idle at
// random, and one phase stalls the response side long enough to block input.
// ============================================================================
`timescale 1ns / 1ps

module tb_kiss_frame_receiver_core;
   import kfr_pkg::*;

   localparam int BUF_DEPTH = BUF_DEPTH_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic               frame_ready;
      logic [LEN_W-1:0]   frame_length;
      logic [BYTE_W-1:0]  read_data;
      logic [EV_W-1:0]    event_res;
   } kiss_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic [INDEX_W-1:0]  req_read_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_frame_ready;
   logic [LEN_W-1:0]    rsp_frame_length;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic [EV_W-1:0]     rsp_event_res;

   logic [BYTE_W-1:0]   frame_mem [2][BUF_DEPTH];
   bit                  byte_written [2][BUF_DEPTH];
   bit                  bank_sel = 1'b0;
   logic [INDEX_W-1:0]  main_head = '0;
   logic [INDEX_W-1:0]  spare_head = '0;
   bit                  frame_held = 1'b0;

   kiss_rsp_type        expected_rsp [$];
   logic [BYTE_W-1:0]   frame_bytes [$];
   bit                  fast_mode = 1'b0;
   int unsigned         rsp_hold_cycles = 0;
   int unsigned         error_count = 0;
   int unsigned         requests_sent = 0;
   int unsigned         frames_accepted = 0;
   int unsigned         frames_dropped = 0;
   int unsigned         reads_done = 0;
   int unsigned         releases_done = 0;

   kiss_frame_receiver_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_rx_byte      (req_rx_byte),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_read_data    (rsp_read_data),
      .rsp_event_res    (rsp_event_res)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_kiss_frame_receiver_core failed");
      $finish;
   end

   function automatic bit frame_passes();
      if (main_head < MIN_FRAME_LEN) return 1'b0;
      if ((frame_mem[bank_sel][0] & CMD_NIBBLE_MASK) != 0) return 1'b0;
      for (int k = 1; k <= LAST_CHECKED; k++)
         if (frame_mem[bank_sel][k][0]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [EV_W-1:0] absorb_byte(input logic [BYTE_W-1:0] b);
      bit                 bsel;
      logic [INDEX_W-1:0] head;
      bsel = frame_held ? !bank_sel : bank_sel;
      head = frame_held ? spare_head : main_head;
      if (b == FEND) begin
         if (frame_held) begin
            spare_head = '0;
         end else if (main_head != 0) begin
            if (frame_passes()) begin
               frame_held = 1'b1;
               spare_head = '0;
               frames_accepted++;
               return EV_ACCEPT;
            end
            main_head = '0;
            frames_dropped++;
            return EV_DISCARD;
         end
         return EV_NONE;
      end
      if (head != 0 && frame_mem[bsel][head - 1] == FESC && (b == TFEND || b == TFESC)) begin
         frame_mem[bsel][head - 1] = (b == TFEND) ? FEND : FESC;
         return EV_NONE;
      end
      frame_mem[bsel][head] = b;
      byte_written[bsel][head] = 1'b1;
      head = head + 1'b1;
      if (frame_held) spare_head = head;
      else main_head = head;
      return EV_NONE;
   endfunction

   task automatic predict_response(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
                                   input logic [INDEX_W-1:0] idx, output kiss_rsp_type r);
      logic [INDEX_W-1:0] pos;
      r = '0;
      case (cmd)
         CMD_BYTE: r.event_res = absorb_byte(rx);
         CMD_READ: begin
            pos = idx + 1'b1;
            r.read_data = frame_mem[bank_sel][pos];
            reads_done++;
         end
         CMD_RELEASE: begin
            if (frame_held) begin
               bank_sel = !bank_sel;
               main_head = spare_head;
               spare_head = '0;
               frame_held = 1'b0;
               releases_done++;
            end
         end
         default: ;
      endcase
      r.frame_ready = frame_held;
      if (frame_held && main_head != 0) r.frame_length = main_head - 1'b1;
   endtask

   function automatic bit find_readable(output logic [INDEX_W-1:0] idx);
      int unsigned start;
      int unsigned pos;
      idx = '0;
      start = $urandom_range(1, BUF_DEPTH - 1);
      for (int n = 0; n < BUF_DEPTH - 1; n++) begin
         pos = 1 + (start - 1 + n) % (BUF_DEPTH - 1);
         if (byte_written[bank_sel][pos]) begin
            idx = INDEX_W'(pos - 1);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_content_byte();
      case ($urandom_range(0, 31))
         0: return FEND;
         1: return FESC;
         2: return TFEND;
         3: return TFESC;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Entered and left at a falling edge; valid stays high when the next
   // request follows without a gap.
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
                               input logic [INDEX_W-1:0] idx);
      int unsigned  gap;
      kiss_rsp_type r;
      gap = fast_mode ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_rx_byte    <= rx;
      req_read_index <= idx;
      do @(posedge clock); while (!req_ready);
      predict_response(cmd, rx, idx, r);
      expected_rsp.push_back(r);
      if (cmd != CMD_UNUSED) requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_request(CMD_BYTE, b, INDEX_W'($urandom_range(0, 510)));
   endtask

   task automatic send_read();
      logic [INDEX_W-1:0] idx;
      if (find_readable(idx)) send_request(CMD_READ, BYTE_W'($urandom_range(0, 255)), idx);
   endtask

   task automatic send_release();
      send_request(CMD_RELEASE, BYTE_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, 510)));
   endtask

   // A sloppy frame sometimes puts a byte on the line without escaping it.
   task automatic send_frame(input bit sloppy);
      foreach (frame_bytes[i]) begin
         if (sloppy && $urandom_range(0, 15) == 0) begin
            send_byte(frame_bytes[i]);
         end else if (frame_bytes[i] == FEND) begin
            send_byte(FESC);
            send_byte(TFEND);
         end else if (frame_bytes[i] == FESC) begin
            send_byte(FESC);
            send_byte(TFESC);
         end else begin
            send_byte(frame_bytes[i]);
         end
      end
      send_byte(FEND);
   endtask

   task automatic fill_frame(input int unsigned len);
      frame_bytes.delete();
      for (int i = 0; i < len; i++) begin
         if (i == 0) frame_bytes.push_back(pick_content_byte() & 8'hF0);
         else if (i <= LAST_CHECKED) frame_bytes.push_back(pick_content_byte() & 8'hFE);
         else frame_bytes.push_back(pick_content_byte());
      end
   endtask

   task automatic flush_frames();
      if (frame_held) send_release();
      send_byte(FEND);
   endtask

   task automatic test_idle_commands();
      send_byte(FEND);
      send_release();
      send_request(CMD_UNUSED, 8'hFF, 9'h1FE);
      send_request(CMD_UNUSED, 8'h00, 9'h001);
   endtask

   task automatic test_escape_sequences();
      send_byte(8'h00);
      send_byte(FESC);
      send_byte(TFEND);
      send_byte(FESC);
      send_byte(TFESC);
      send_byte(FESC);
      send_byte(TFESC);
      send_byte(TFEND);
      send_byte(FESC);
      send_byte(8'h41);
      send_byte(8'hFF);
      send_request(CMD_READ, 8'h00, 9'd0);
      send_request(CMD_READ, 8'hFF, 9'd1);
      send_request(CMD_READ, 8'h00, 9'd2);
      send_request(CMD_READ, 8'hFF, 9'd3);
      send_byte(FEND);
   endtask

   task automatic test_frame_checks();
      fill_frame(MIN_FRAME_LEN);
      send_frame(1'b0);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(FEND);
      send_byte(8'h30);
      send_read();
      send_release();
      send_read();
      send_byte(FEND);
      fill_frame(MIN_FRAME_LEN - 1);
      send_frame(1'b0);
      fill_frame(MIN_FRAME_LEN);
      frame_bytes[0] = frame_bytes[0] | 8'h01;
      send_frame(1'b0);
      fill_frame(MIN_FRAME_LEN);
      frame_bytes[LAST_CHECKED] = frame_bytes[LAST_CHECKED] | 8'h01;
      send_frame(1'b0);
      fill_frame(MIN_FRAME_LEN + 2);
      frame_bytes[LAST_CHECKED + 1] = frame_bytes[LAST_CHECKED + 1] | 8'h01;
      send_frame(1'b0);
      send_release();
   endtask

   // The write head wraps past the end of the store before the end marker.
   task automatic test_wrapped_frame();
      flush_frames();
      frame_bytes.delete();
      for (int i = 0; i < BUF_DEPTH + 18; i++) frame_bytes.push_back(BYTE_W'((i * 2) % 256));
      send_frame(1'b0);
      send_request(CMD_READ, 8'h00, 9'd0);
      send_request(CMD_READ, 8'hFF, 9'd510);
      send_read();
      send_release();
   endtask

   task automatic test_output_stall();
      rsp_hold_cycles = 300;
      fast_mode = 1'b1;
      repeat (24) send_byte(pick_content_byte());
      send_read();
      fast_mode = 1'b0;
      flush_frames();
   endtask

   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned choice;
      int unsigned len;
      int unsigned flaw;
      stop_at = requests_sent + n_items;
      while (requests_sent < stop_at) begin
         fast_mode = ($urandom_range(0, 9) == 0);
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            choice = $urandom_range(0, 99);
            len = (choice < 8) ? $urandom_range(1, 15) :
                  (choice < 97) ? $urandom_range(16, 48) : $urandom_range(49, 200);
            fill_frame(len);
            flaw = $urandom_range(0, 9);
            if (flaw == 0)
               frame_bytes[0] = frame_bytes[0] | (8'h01 << $urandom_range(0, 3));
            else if (flaw == 1)
               frame_bytes[$urandom_range(1, LAST_CHECKED) % len] =
                  frame_bytes[$urandom_range(1, LAST_CHECKED) % len] | 8'h01;
            send_frame(flaw == 2);
            if (frame_held) begin
               repeat ($urandom_range(0, 3)) send_read();
               if ($urandom_range(0, 2) == 0) begin
                  repeat ($urandom_range(1, 20)) send_byte(pick_content_byte());
                  if ($urandom_range(0, 1) == 0) send_byte(FEND);
               end
               if ($urandom_range(0, 4) != 0) send_release();
            end
         end else if (choice < 80) begin
            repeat ($urandom_range(1, 8)) send_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (choice < 90) begin
            repeat ($urandom_range(1, 4)) send_read();
         end else if (choice < 98) begin
            send_release();
         end else begin
            send_request(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)),
                         INDEX_W'($urandom_range(0, 510)));
         end
      end
      fast_mode = 1'b0;
   endtask

   initial begin
      int unsigned  stall;
      kiss_rsp_type want;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = fast_mode ? 0 : $urandom_range(0, 14);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_rsp.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_frame_ready !== want.frame_ready) begin
               $error("frame_ready: expected %0d, got %0d", want.frame_ready, rsp_frame_ready);
               error_count++;
            end
            if (rsp_frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d", want.frame_length,
                      rsp_frame_length);
               error_count++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_event_res);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      req_valid      = 1'b0;
      req_command    = CMD_BYTE;
      req_rx_byte    = '0;
      req_read_index = '0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_commands();
      test_escape_sequences();
      test_frame_checks();
      test_wrapped_frame();
      test_output_stall();
      test_random_traffic(1220);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests: %0d frames accepted, %0d dropped, %0d byte reads,",
               requests_sent, frames_accepted, frames_dropped, reads_done);
      $display("%0d releases, with escapes, a wrapped frame and a long response stall.",
               releases_done);
      if (error_count == 0) begin
         $display("tb_kiss_frame_receiver_core passed");
      end else begin
         $display("tb_kiss_frame_receiver_core failed");
      end
      $finish;
   end

endmodule
